/* sv/wolss_pkg.sv */
`timescale 1ns / 1ps
package wolss_pkg;

    localparam int SLOTS_DEFAULT = 1024;

    // Request kinds.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_INVAL = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNWRITTEN    = 3'd1;
    localparam logic [2:0] ST_INVALID      = 3'd2;
    localparam logic [2:0] ST_WRONG_OBJECT = 3'd3;
    localparam logic [2:0] ST_EXISTS       = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE    = 3'd5;
    localparam logic [2:0] ST_READ_ONLY    = 3'd6;
    localparam logic [2:0] ST_BAD_CONFIG   = 3'd7;

    // Slot state codes.
    localparam logic [1:0] SLOT_UNUSED  = 2'd0;
    localparam logic [1:0] SLOT_TAKEN   = 2'd1;
    localparam logic [1:0] SLOT_INVALID = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_STRIPE  = 2'd0;
    localparam logic [1:0] REG_ENTRIES = 2'd1;
    localparam logic [1:0] REG_ESIZE   = 2'd2;
    localparam logic [1:0] REG_OBJID   = 2'd3;

    // Input request as it travels through the front queue.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] position;
        logic [15:0] data_length;
        logic        force_req;
    } req_t;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_rsp_t;

endpackage

/* sv/wolss_ram.sv */
`timescale 1ns / 1ps
module wolss_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/wolss_front.sv */
`timescale 1ns / 1ps
module wolss_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  wolss_pkg::req_t s_req,
    output logic            q_valid,
    input  logic            q_pop,
    output wolss_pkg::req_t q_req
);

    // Two-entry queue decouples acceptance from execution.
    wolss_pkg::req_t ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = ent_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    // Write position is the slot after the oldest valid entry.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[rd_reg ^ (cnt_reg == 2'd1)] <= s_req;
        end
    end

endmodule

/* sv/wolss_div.sv */
`timescale 1ns / 1ps
module wolss_div (
    input  logic                clk,
    input  logic                rst_n,
    input  wolss_pkg::div_cmd_t cmd,
    output wolss_pkg::div_rsp_t rsp
);

    // Restoring divider, one quotient bit per cycle.
    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {r_reg, q_reg[63]};
    assign diff  = trial - {1'b0, d_reg};

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg <= cmd.dividend;
            r_reg <= 64'd0;
            d_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                r_reg <= diff[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

endmodule

/* sv/wolss_back.sv */
`timescale 1ns / 1ps
module wolss_back #(
    parameter int SLOTS = wolss_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  wolss_pkg::req_t     q_req,
    input  logic [15:0]         stripe_cnt,
    input  logic [10:0]         slots_per_obj,
    input  logic [15:0]         payload_max,
    input  logic [63:0]         target_obj,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          status,
    output logic [63:0]         object_number,
    output logic [25:0]         byte_offset,
    output logic [16:0]         slot_bytes
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (AW > 11) ? AW : 11;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_DIV1  = 8'b00000010,
        S_DIV2  = 8'b00000100,
        S_MUL   = 8'b00001000,
        S_READ  = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_CLEAR = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    wolss_pkg::div_cmd_t dcmd;
    wolss_pkg::div_rsp_t drsp;
    wolss_pkg::req_t     req_reg;
    logic [63:0] pmod_reg;
    logic [63:0] qhi_reg;
    logic [63:0] slot_reg;
    logic [47:0] mlo_reg;
    logic [31:0] mhi_reg;
    logic [63:0] prod_reg;
    logic [42:0] offs_reg;
    logic [16:0] ssize;
    logic        bad_cfg;
    logic        slot_ok;
    logic [AW-1:0] addr;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [1:0]  ram_wdata;
    logic [1:0]  cur;
    logic [AW:0] clr_reg;
    logic [2:0]  st_comb;
    logic [1:0]  nst_comb;
    logic        wr_comb;

    assign ssize   = {1'b0, payload_max} + 17'd1;
    assign bad_cfg = (stripe_cnt == 16'd0) || (slots_per_obj == 11'd0) ||
                     (payload_max == 16'd0) ||
                     ({{(CW - 11){1'b0}}, slots_per_obj} > CW'(SLOTS));
    assign slot_ok = (slot_reg < 64'(SLOTS));
    assign addr    = slot_reg[AW-1:0];

    wolss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dcmd),
        .rsp   (drsp)
    );

    wolss_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (cur)
    );

    // Divider commands for the two divisions.
    always_comb
    begin
        dcmd.start    = 1'b0;
        dcmd.dividend = q_req.position;
        dcmd.divisor  = {48'd0, stripe_cnt};
        if (state_reg == S_IDLE && q_valid && !bad_cfg && !m_tvalid)
        begin
            dcmd.start = 1'b1;
        end
        else if (state_reg == S_DIV1 && drsp.done)
        begin
            dcmd.start    = 1'b1;
            dcmd.dividend = drsp.quotient;
            dcmd.divisor  = {53'd0, slots_per_obj};
        end
    end

    // Slot state decision.
    always_comb
    begin
        st_comb  = wolss_pkg::ST_OK;
        nst_comb = cur;
        wr_comb  = 1'b0;
        if (prod_reg != target_obj || !slot_ok)
        begin
            st_comb = wolss_pkg::ST_WRONG_OBJECT;
        end
        else
        begin
            case (req_reg.req_type)
                wolss_pkg::REQ_WRITE:
                begin
                    if (cur != wolss_pkg::SLOT_UNUSED)
                        st_comb = wolss_pkg::ST_EXISTS;
                    else if (req_reg.data_length > payload_max)
                        st_comb = wolss_pkg::ST_TOO_LARGE;
                    else
                    begin
                        nst_comb = wolss_pkg::SLOT_TAKEN;
                        wr_comb  = 1'b1;
                    end
                end
                wolss_pkg::REQ_INVAL:
                begin
                    if (req_reg.force_req || cur != wolss_pkg::SLOT_TAKEN)
                    begin
                        nst_comb = wolss_pkg::SLOT_INVALID;
                        wr_comb  = 1'b1;
                    end
                    else
                        st_comb = wolss_pkg::ST_READ_ONLY;
                end
                default:
                begin
                    if (cur == wolss_pkg::SLOT_TAKEN)
                        st_comb = wolss_pkg::ST_OK;
                    else if (cur == wolss_pkg::SLOT_UNUSED)
                        st_comb = wolss_pkg::ST_UNWRITTEN;
                    else
                        st_comb = wolss_pkg::ST_INVALID;
                end
            endcase
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_EXEC && wr_comb);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg[AW-1:0] : addr;
    assign ram_wdata = (state_reg == S_CLEAR) ? wolss_pkg::SLOT_UNUSED : nst_comb;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !m_tvalid;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (AW + 1)'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (q_pop && !bad_cfg) state_next = S_DIV1;
            S_DIV1:  if (drsp.done) state_next = S_DIV2;
            S_DIV2:  if (drsp.done) state_next = S_MUL;
            S_MUL:   state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            // A new result is only raised while the output is empty.
            if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            else if ((q_pop && bad_cfg) || state_reg == S_EXEC)
                m_tvalid <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            req_reg <= q_req;
        end
        if (state_reg == S_DIV1 && drsp.done)
        begin
            pmod_reg <= drsp.remainder;
        end
        if (state_reg == S_DIV2 && drsp.done)
        begin
            qhi_reg  <= drsp.quotient;
            slot_reg <= drsp.remainder;
        end
        // The object number product is built from two 32 by 16 bit halves.
        if (state_reg == S_MUL)
        begin
            mlo_reg  <= qhi_reg[31:0] * stripe_cnt;
            mhi_reg  <= qhi_reg[63:32] * stripe_cnt;
            offs_reg <= slot_reg[25:0] * ssize;
        end
        if (state_reg == S_READ)
        begin
            prod_reg <= {mhi_reg, 32'd0} + {16'd0, mlo_reg} + pmod_reg;
        end
        if (q_pop && bad_cfg)
        begin
            status        <= wolss_pkg::ST_BAD_CONFIG;
            object_number <= 64'd0;
            byte_offset   <= 26'd0;
            slot_bytes    <= 17'd0;
        end
        else if (state_reg == S_EXEC)
        begin
            status        <= st_comb;
            object_number <= prod_reg;
            byte_offset   <= offs_reg[25:0];
            slot_bytes    <= ssize;
        end
    end

endmodule

/* sv/write_once_log_slot_store.sv */
`timescale 1ns / 1ps
// Write-once log slot store.
// Requests enter on the s_axis channel: tdata holds req_type, position,
// data_length and force_req. One result leaves on m_axis per request:
// tdata holds status, object_number, byte_offset and the slot size.
// Registers are written over the APB port: stripe count at 0x00, slots per
// object at 0x08, payload size at 0x10 and target object at 0x18.
// A two-entry queue lets requests be taken while the back end works.
// With the back end idle, a request passes the queue register, then two passes
// of the shared radix-2 divider (64 steps and a handoff each), the multiply
// states S_MUL and S_READ, of which the second also reads the slot state,
// and the update state S_EXEC, which registers the result.
// The back end starts the next request only once it is idle and its last result has been taken.
// A bad configuration is answered as soon as the request leaves the queue, with no division.
// After reset the slot state memory is cleared, one entry a cycle, through all
// SLOTS entries; requests wait meanwhile, register writes are taken.
// While the receiver stalls, the result holds and the back end waits;
// the queue still fills until it holds two requests.
module write_once_log_slot_store #(
    parameter int SLOTS = wolss_pkg::SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0], position[65:2], data_length[81:66], force_req[82]
    input  logic [87:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], object_number[66:3], byte_offset[92:67], slot size[109:93]
    output logic [111:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    wolss_pkg::req_t s_req, q_req;
    logic q_valid, q_pop;
    logic [15:0] sw_reg;
    logic [10:0] epo_reg;
    logic [15:0] es_reg;
    logic [63:0] oid_reg;
    logic [2:0]  status;
    logic [63:0] objno;
    logic [25:0] offs;
    logic [16:0] ssz;
    logic [1:0]  ridx;

    assign s_req.req_type    = s_axis_tdata[1:0];
    assign s_req.position    = s_axis_tdata[65:2];
    assign s_req.data_length = s_axis_tdata[81:66];
    assign s_req.force_req   = s_axis_tdata[82];

    assign m_axis_tdata = {2'd0, ssz, offs, objno, status};
    assign pready = 1'b1;
    assign ridx   = paddr[4:3];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= 16'd1;
            epo_reg <= 11'd1024;
            es_reg  <= 16'd1;
            oid_reg <= 64'd0;
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
        begin
            case (ridx)
                wolss_pkg::REG_STRIPE:  sw_reg  <= pwdata[15:0];
                wolss_pkg::REG_ENTRIES: epo_reg <= pwdata[10:0];
                wolss_pkg::REG_ESIZE:   es_reg  <= pwdata[15:0];
                wolss_pkg::REG_OBJID:   oid_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (ridx)
            wolss_pkg::REG_STRIPE:  prdata = {48'd0, sw_reg};
            wolss_pkg::REG_ENTRIES: prdata = {53'd0, epo_reg};
            wolss_pkg::REG_ESIZE:   prdata = {48'd0, es_reg};
            default:                prdata = oid_reg;
        endcase
    end

    wolss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_req    (s_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    wolss_back #(.SLOTS(SLOTS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_req         (q_req),
        .stripe_cnt    (sw_reg),
        .slots_per_obj (epo_reg),
        .payload_max   (es_reg),
        .target_obj    (oid_reg),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .status        (status),
        .object_number (objno),
        .byte_offset   (offs),
        .slot_bytes    (ssz)
    );

endmodule

/* sv/wolss_checker.sv */
`timescale 1ns / 1ps
module wolss_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         pready
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Bad configuration results carry zero layout fields.
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == wolss_pkg::ST_BAD_CONFIG
        |-> m_axis_tdata[109:3] == '0)
        else $error("bad_config result with layout fields");

    // No result is offered during reset.
    a_nores: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // The configuration port never waits.
    a_ready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind write_once_log_slot_store wolss_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
